/* rtl/csc_pkg.sv */
package csc_pkg;

   // internal data word and angle accumulator (30 fraction bits)
   localparam int IW = 64;
   localparam int AW = 36;

   localparam logic [29:0] KINV_Q30 = 30'd652032874;
   localparam logic signed [AW-1:0] PI_Q30 = 36'sh0C90FDAA2;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sh06487ED51;
   localparam logic signed [AW-1:0] TWO_PI_Q30 = 36'sh1921FB544;
   localparam logic [IW-1:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
   localparam logic [IW-1:0] ROUND_Q30 = 64'h0000000020000000;

   typedef enum logic [2:0] {
      OP_POLAR_TO_RECT = 3'd0,
      OP_RECT_TO_POLAR = 3'd1,
      OP_CYL_TO_RECT   = 3'd2,
      OP_RECT_TO_CYL   = 3'd3,
      OP_SPH_TO_RECT   = 3'd4,
      OP_RECT_TO_SPH   = 3'd5
   } op_type;

   function automatic logic signed [AW-1:0] atan_q30(input int i);
      logic signed [AW-1:0] t;
      case (i)
         0: begin
            t = 36'sh03243F6A8;
         end
         1: begin
            t = 36'sh01DAC6705;
         end
         2: begin
            t = 36'sh00FADBAFC;
         end
         3: begin
            t = 36'sh007F56EA6;
         end
         4: begin
            t = 36'sh003FEAB76;
         end
         5: begin
            t = 36'sh001FFD55B;
         end
         6: begin
            t = 36'sh000FFFAAA;
         end
         7: begin
            t = 36'sh0007FFF55;
         end
         8: begin
            t = 36'sh0003FFFEA;
         end
         9: begin
            t = 36'sh0001FFFFD;
         end
         default: begin
            t = (i <= 30) ? (AW'(1) <<< (30 - i)) : '0;
         end
      endcase
      return t;
   endfunction

endpackage

/* rtl/coordinate_system_converter.sv */
// throughput: one item per cycle while results are popped and no queue fills; angle
//   reduction is one bit per stage and each cordic pass is one iteration per stage,
//   so every step is its own pipeline stage
// reset: synchronous, clears all valid flags and queue pointers; no clearing pass
module coordinate_system_converter import csc_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [2:0]                   req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_in_first,
   input  logic signed [DATA_WIDTH-1:0] req_in_second,
   input  logic signed [DATA_WIDTH-1:0] req_in_third,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [DATA_WIDTH-1:0] rsp_out_first,
   output logic signed [DATA_WIDTH-1:0] rsp_out_second,
   output logic signed [DATA_WIDTH-1:0] rsp_out_third
);

   localparam int DW = DATA_WIDTH;
   localparam int MW = 3 + 3 * DW + 2 * AW;
   localparam int OW = 3 * DW;

   logic f_push, mid_full, mid_empty, b_pop, o_push, o_full;
   logic [2:0] f_op;
   logic signed [DW-1:0] f_a, f_b, f_c;
   logic signed [AW-1:0] f_theta, f_phi;
   logic [MW-1:0] mid_dout;
   logic signed [DW-1:0] o_first, o_second, o_third;
   logic [OW-1:0] o_dout;

   csc_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .op        (req_operation),
      .a         (req_in_first),
      .b         (req_in_second),
      .c         (req_in_third),
      .q_full    (mid_full),
      .out_push  (f_push),
      .out_op    (f_op),
      .out_a     (f_a),
      .out_b     (f_b),
      .out_c     (f_c),
      .out_theta (f_theta),
      .out_phi   (f_phi)
   );

   csc_queue #(.W(MW), .DEPTH(4)) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   ({f_op, f_a, f_b, f_c, f_theta, f_phi}),
      .full  (mid_full),
      .pop   (b_pop),
      .dout  (mid_dout),
      .empty (mid_empty)
   );

   csc_back #(.DW(DW), .FB(FRAC_BITS), .N(CORDIC_ITERATIONS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!mid_empty),
      .in_pop     (b_pop),
      .in_op      (mid_dout[MW-1 -: 3]),
      .in_a       (mid_dout[MW-4 -: DW]),
      .in_b       (mid_dout[MW-4-DW -: DW]),
      .in_c       (mid_dout[MW-4-2*DW -: DW]),
      .in_theta   (mid_dout[2*AW-1 -: AW]),
      .in_phi     (mid_dout[AW-1:0]),
      .out_full   (o_full),
      .out_push   (o_push),
      .out_first  (o_first),
      .out_second (o_second),
      .out_third  (o_third)
   );

   csc_queue #(.W(OW), .DEPTH(2)) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (o_push),
      .din   ({o_first, o_second, o_third}),
      .full  (o_full),
      .pop   (rsp_pop),
      .dout  (o_dout),
      .empty (rsp_empty)
   );

   always_comb begin
      rsp_out_first = o_dout[3*DW-1 -: DW];
      rsp_out_second = o_dout[2*DW-1 -: DW];
      rsp_out_third = o_dout[DW-1:0];
   end

endmodule

/* rtl/csc_queue.sv */
module csc_queue #(
   parameter int W = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] dout,
   output logic         empty
);

   localparam int PW = $clog2(DEPTH);

   logic [W-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full = (count_ff == (PW+1)'(DEPTH));
      empty = (count_ff == '0);
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_in = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      dout = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

/* rtl/csc_front.sv */
module csc_front import csc_pkg::*; #(
   parameter int DW = 32,
   parameter int FB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [2:0]           op,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] b,
   input  logic signed [DW-1:0] c,
   input  logic                 q_full,
   output logic                 out_push,
   output logic [2:0]           out_op,
   output logic signed [DW-1:0] out_a,
   output logic signed [DW-1:0] out_b,
   output logic signed [DW-1:0] out_c,
   output logic signed [AW-1:0] out_theta,
   output logic signed [AW-1:0] out_phi
);

   localparam int ZB = 60 - FB;
   localparam int RS = DW + ZB;
   localparam int NS = RS + 3;
   localparam int SW = 3 + 3 * DW;

   logic valid_ff [NS];
   logic [SW-1:0] side_ff [NS];
   logic en;
   logic signed [DW-1:0] lane_in [2];
   logic signed [AW-1:0] q_ff [2];

   always_comb begin
      en = !(valid_ff[NS-1] && q_full);
      full = !en;
      out_push = valid_ff[NS-1] && !q_full;
      lane_in[0] = b;
      lane_in[1] = c;
      out_op = side_ff[NS-1][SW-1 -: 3];
      out_a = side_ff[NS-1][3*DW-1 -: DW];
      out_b = side_ff[NS-1][2*DW-1 -: DW];
      out_c = side_ff[NS-1][DW-1:0];
      out_theta = q_ff[0];
      out_phi = q_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= push;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= {op, a, b, c};
         for (int k = 1; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // exact remainder modulo two pi, one bit per stage
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RS-1:0] w_ff [RS];
      logic neg_ff [RS+1];
      logic [IW-1:0] r_ff [RS+2];
      logic [DW-1:0] mag_in;
      logic [IW-1:0] sum_in;
      logic signed [AW-1:0] q_in;

      always_comb begin
         mag_in = lane_in[l][DW-1] ? DW'(-lane_in[l]) : DW'(lane_in[l]);
         sum_in = r_ff[RS+1] + ROUND_Q30;
         q_in = AW'(sum_in[IW-1:30]);
         if (q_in > PI_Q30) begin
            q_in = q_in - TWO_PI_Q30;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[0] <= {mag_in, ZB'(0)};
            neg_ff[0] <= lane_in[l][DW-1];
            r_ff[0] <= '0;
            r_ff[RS+1] <= (neg_ff[RS] && r_ff[RS] != '0) ? TWO_PI_Q60 - r_ff[RS] : r_ff[RS];
            q_ff[l] <= q_in;
         end
      end

      for (genvar s = 1; s <= RS; s++) begin : g_step
         logic [IW-1:0] t_in;

         always_comb begin
            t_in = {r_ff[s-1][IW-2:0], w_ff[s-1][RS-s]};
            if (t_in >= TWO_PI_Q60) begin
               t_in = t_in - TWO_PI_Q60;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[s] <= t_in;
               neg_ff[s] <= neg_ff[s-1];
            end
         end

         if (s < RS) begin : g_word
            always_ff @(posedge clock) begin
               if (en) begin
                  w_ff[s] <= w_ff[s-1];
               end
            end
         end
      end
   end

endmodule

/* rtl/csc_cordic.sv */
module csc_cordic import csc_pkg::*; #(
   parameter int N = 24,
   parameter int SW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic                 in_rot,
   input  logic signed [IW-1:0] in_x,
   input  logic signed [IW-1:0] in_y,
   input  logic signed [AW-1:0] in_z,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [IW-1:0] out_x,
   output logic signed [IW-1:0] out_y,
   output logic signed [AW-1:0] out_z,
   output logic [SW-1:0]        out_side
);

   localparam int NS = N + 3;

   logic valid_ff [NS];
   logic [SW-1:0] side_ff [NS];
   logic rot_ff [N+1];
   logic zero_ff [N+1];
   logic signed [IW-1:0] x_ff [N+1];
   logic signed [IW-1:0] y_ff [N+1];
   logic signed [AW-1:0] z_ff [N+3];

   logic signed [IW-1:0] x_in, y_in;
   logic signed [AW-1:0] z_in, zw_in;
   logic zero_in;
   logic [IW-1:0] ux_in, uy_in;
   logic negx_ff, negy_ff;
   logic [61:0] phx_ff, plx_ff, phy_ff, ply_ff;
   logic [IW-1:0] rx_in, ry_in;
   logic signed [IW-1:0] xo_ff, yo_ff;

   // quadrant fold ahead of the iterations
   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = in_z;
      zero_in = 1'b0;
      if (in_rot) begin
         if (in_z > HALF_PI_Q30) begin
            z_in = in_z - PI_Q30;
            x_in = -in_x;
            y_in = -in_y;
         end else if (in_z < -HALF_PI_Q30) begin
            z_in = in_z + PI_Q30;
            x_in = -in_x;
            y_in = -in_y;
         end
      end else begin
         z_in = '0;
         zero_in = (in_x == '0) && (in_y == '0);
         if (in_x < 0) begin
            z_in = (in_y >= 0) ? PI_Q30 : -PI_Q30;
            x_in = -in_x;
            y_in = -in_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
         rot_ff[0] <= in_rot;
         zero_ff[0] <= zero_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [AW-1:0] ATAN = atan_q30(i);
      logic signed [IW-1:0] sx, sy;
      logic ccw;

      always_comb begin
         sx = x_ff[i] >>> i;
         sy = y_ff[i] >>> i;
         ccw = rot_ff[i] ? !z_ff[i][AW-1] : y_ff[i][IW-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (ccw) begin
               x_ff[i+1] <= x_ff[i] - sy;
               y_ff[i+1] <= y_ff[i] + sx;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + sy;
               y_ff[i+1] <= y_ff[i] - sx;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            rot_ff[i+1] <= rot_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // gain removal: two partial products, then sum and round
   always_comb begin
      ux_in = x_ff[N][IW-1] ? IW'(-x_ff[N]) : IW'(x_ff[N]);
      uy_in = y_ff[N][IW-1] ? IW'(-y_ff[N]) : IW'(y_ff[N]);
      zw_in = z_ff[N];
      if (zero_ff[N]) begin
         zw_in = '0;
      end else if (z_ff[N] > PI_Q30) begin
         zw_in = z_ff[N] - TWO_PI_Q30;
      end else if (z_ff[N] <= -PI_Q30) begin
         zw_in = z_ff[N] + TWO_PI_Q30;
      end
      rx_in = {phx_ff, 2'b00} + ((IW'(plx_ff) + ROUND_Q30) >> 30);
      ry_in = {phy_ff, 2'b00} + ((IW'(ply_ff) + ROUND_Q30) >> 30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         negx_ff <= x_ff[N][IW-1];
         negy_ff <= y_ff[N][IW-1];
         phx_ff <= ux_in[IW-1:32] * KINV_Q30;
         plx_ff <= ux_in[31:0] * KINV_Q30;
         phy_ff <= uy_in[IW-1:32] * KINV_Q30;
         ply_ff <= uy_in[31:0] * KINV_Q30;
         z_ff[N+1] <= zw_in;
         xo_ff <= negx_ff ? -rx_in : rx_in;
         yo_ff <= negy_ff ? -ry_in : ry_in;
         z_ff[N+2] <= z_ff[N+1];
      end
   end

   always_comb begin
      out_valid = valid_ff[NS-1];
      out_side = side_ff[NS-1];
      out_x = xo_ff;
      out_y = yo_ff;
      out_z = z_ff[N+2];
   end

endmodule

/* rtl/csc_back.sv */
module csc_back import csc_pkg::*; #(
   parameter int DW = 32,
   parameter int FB = 16,
   parameter int N = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_pop,
   input  logic [2:0]           in_op,
   input  logic signed [DW-1:0] in_a,
   input  logic signed [DW-1:0] in_b,
   input  logic signed [DW-1:0] in_c,
   input  logic signed [AW-1:0] in_theta,
   input  logic signed [AW-1:0] in_phi,
   input  logic                 out_full,
   output logic                 out_push,
   output logic signed [DW-1:0] out_first,
   output logic signed [DW-1:0] out_second,
   output logic signed [DW-1:0] out_third
);

   localparam int GUARD = 61 - DW;
   localparam int SWA = 3 + 2 * DW + AW;
   localparam int SWB = 3 + DW + 2 * IW + AW;
   localparam int ASH = 30 - FB;
   localparam int ASH_M1 = (ASH > 0) ? ASH - 1 : 0;
   localparam logic signed [IW-1:0] DROUND = IW'(1) <<< (GUARD - 1);
   localparam logic signed [IW-1:0] AROUND = (ASH > 0) ? (IW'(1) <<< ASH_M1) : '0;
   localparam logic signed [IW-1:0] DMAX = (IW'(1) <<< (DW - 1)) - IW'(1);
   localparam logic signed [IW-1:0] DMIN = -(IW'(1) <<< (DW - 1));

   function automatic logic signed [IW-1:0] widen(input logic signed [DW-1:0] v);
      return IW'(v) <<< GUARD;
   endfunction

   function automatic logic [DW-1:0] sat(input logic signed [IW-1:0] v);
      logic [DW-1:0] r;
      if (v > DMAX) begin
         r = DMAX[DW-1:0];
      end else if (v < DMIN) begin
         r = DMIN[DW-1:0];
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] data_out(input logic signed [IW-1:0] v);
      logic signed [IW-1:0] t;
      t = (v + DROUND) >>> GUARD;
      return sat(t);
   endfunction

   function automatic logic [DW-1:0] angle_out(input logic signed [AW-1:0] q);
      logic signed [IW-1:0] t;
      t = (IW'(q) + AROUND) >>> ASH;
      return sat(t);
   endfunction

   logic en;
   logic a_rot, b_rot;
   logic signed [IW-1:0] a_y, b_x, b_y;
   logic a_valid_o, b_valid_o;
   logic signed [IW-1:0] ax_o, ay_o, bx_o, by_o;
   logic signed [AW-1:0] az_o, bz_o;
   logic [SWA-1:0] a_side_o;
   logic [SWB-1:0] b_side_o;
   op_type a_op_o, b_op_o;
   logic signed [DW-1:0] a_a_o, a_c_o, b_c_o;
   logic signed [AW-1:0] a_th_o, b_ang_o;
   logic signed [IW-1:0] b_xa_o, b_ya_o;

   always_comb begin
      en = !(b_valid_o && out_full);
      in_pop = in_valid && en;
      out_push = b_valid_o && !out_full;
      a_rot = (in_op == OP_SPH_TO_RECT);
      a_y = a_rot ? '0 : widen(in_b);
   end

   // first pass: elevation turn, or the x-y vector
   csc_cordic #(.N(N), .SW(SWA)) u_pass_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_pop),
      .in_rot    (a_rot),
      .in_x      (widen(in_a)),
      .in_y      (a_y),
      .in_z      (in_phi),
      .in_side   ({in_op, in_a, in_c, in_theta}),
      .out_valid (a_valid_o),
      .out_x     (ax_o),
      .out_y     (ay_o),
      .out_z     (az_o),
      .out_side  (a_side_o)
   );

   always_comb begin
      a_op_o = op_type'(a_side_o[SWA-1 -: 3]);
      a_a_o = a_side_o[SWA-4 -: DW];
      a_c_o = a_side_o[SWA-4-DW -: DW];
      a_th_o = a_side_o[AW-1:0];
      b_rot = a_op_o inside {OP_POLAR_TO_RECT, OP_CYL_TO_RECT, OP_SPH_TO_RECT};
      b_x = (a_op_o == OP_SPH_TO_RECT || a_op_o == OP_RECT_TO_SPH) ? ax_o : widen(a_a_o);
      b_y = (a_op_o == OP_RECT_TO_SPH) ? widen(a_c_o) : '0;
   end

   // second pass: azimuth turn, or the elevation vector
   csc_cordic #(.N(N), .SW(SWB)) u_pass_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_o),
      .in_rot    (b_rot),
      .in_x      (b_x),
      .in_y      (b_y),
      .in_z      (a_th_o),
      .in_side   ({a_op_o, a_c_o, ax_o, ay_o, az_o}),
      .out_valid (b_valid_o),
      .out_x     (bx_o),
      .out_y     (by_o),
      .out_z     (bz_o),
      .out_side  (b_side_o)
   );

   always_comb begin
      b_op_o = op_type'(b_side_o[SWB-1 -: 3]);
      b_c_o = b_side_o[SWB-4 -: DW];
      b_xa_o = b_side_o[2*IW+AW-1 -: IW];
      b_ya_o = b_side_o[IW+AW-1 -: IW];
      b_ang_o = b_side_o[AW-1:0];
      out_first = '0;
      out_second = '0;
      out_third = '0;
      case (b_op_o)
         OP_POLAR_TO_RECT: begin
            out_first = data_out(bx_o);
            out_second = data_out(by_o);
         end
         OP_CYL_TO_RECT: begin
            out_first = data_out(bx_o);
            out_second = data_out(by_o);
            out_third = b_c_o;
         end
         OP_RECT_TO_POLAR: begin
            out_first = data_out(b_xa_o);
            out_second = angle_out(b_ang_o);
         end
         OP_RECT_TO_CYL: begin
            out_first = data_out(b_xa_o);
            out_second = angle_out(b_ang_o);
            out_third = b_c_o;
         end
         OP_SPH_TO_RECT: begin
            out_first = data_out(bx_o);
            out_second = data_out(by_o);
            out_third = data_out(b_ya_o);
         end
         OP_RECT_TO_SPH: begin
            out_first = data_out(bx_o);
            out_second = angle_out(b_ang_o);
            out_third = angle_out(bz_o);
         end
         default: begin
            out_first = '0;
         end
      endcase
   end

endmodule

/* rtl/csc_checker.sv */
module csc_checker #(
   parameter int DW = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input logic [2:0]           req_operation,
   input logic signed [DW-1:0] req_in_first,
   input logic signed [DW-1:0] req_in_second,
   input logic signed [DW-1:0] req_in_third,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic signed [DW-1:0] rsp_out_first,
   input logic signed [DW-1:0] rsp_out_second,
   input logic signed [DW-1:0] rsp_out_third
);

   // nothing is left in flight after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // an empty pipeline takes a transfer at once
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_out_first) && $stable(rsp_out_second)
         && $stable(rsp_out_third)))
      else $error("waiting result changed");

endmodule

bind coordinate_system_converter csc_checker #(.DW(DATA_WIDTH)) u_csc_checker (.*);

/* bench/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import csc_pkg::*;

   localparam longint ANG_PI      = 64'sh0C90FDAA2;
   localparam longint ANG_HALF_PI = 64'sh06487ED51;
   localparam longint ANG_TWO_PI  = 64'sh1921FB544;
   localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;
   localparam longint unsigned GAIN_INV = 64'd652032874;
   localparam int GUARD_BITS = 29;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int RANDOM_ITEMS = 1330;
   localparam int QUIET_TAIL = 200;

   typedef struct {
      logic [2:0] op;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] third;
   } coord_item_type;

   typedef struct {
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] third;
   } coord_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [2:0] req_operation = '0;
   logic signed [31:0] req_in_first = '0;
   logic signed [31:0] req_in_second = '0;
   logic signed [31:0] req_in_third = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_out_first;
   logic signed [31:0] rsp_out_second;
   logic signed [31:0] rsp_out_third;

   coord_item_type pending_items[$];
   coord_result_type expected_coords[$];
   int sent_count = 0;
   int recv_count = 0;
   int mismatch_count = 0;
   int total_items = 0;
   int op_seen[8];
   bit quiet = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   coordinate_system_converter uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_operation(req_operation),
      .req_in_first(req_in_first), .req_in_second(req_in_second),
      .req_in_third(req_in_third),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_first(rsp_out_first), .rsp_out_second(rsp_out_second),
      .rsp_out_third(rsp_out_third)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint atan_step(int i);
      longint head[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                           64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                           64'h003FFFEA, 64'h001FFFFD};
      if (i < 10) return head[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
   endfunction

   function automatic longint scale_by_gain(longint a);
      longint unsigned u, hi, lo, r;
      u = (a < 0) ? (64'd0 - longint'(a)) : a;
      hi = u >> 32;
      lo = u & 64'hFFFFFFFF;
      r = ((hi * GAIN_INV) << 2) + ((lo * GAIN_INV + (64'd1 << 29)) >> 30);
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint wrap_angle(longint a);
      longint unsigned mag, r;
      longint q;
      mag = (a < 0) ? (64'd0 - longint'(a)) : a;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         r = (r << 1) | ((mag >> b) & 64'd1);
         if (r >= TWO_PI_Q60) r -= TWO_PI_Q60;
      end
      for (int k = 0; k < 44; k++) begin
         r = r << 1;
         if (r >= TWO_PI_Q60) r -= TWO_PI_Q60;
      end
      if (a < 0 && r != 0) r = TWO_PI_Q60 - r;
      q = longint'((r + (64'd1 << 29)) >> 30);
      if (q > ANG_PI) q -= ANG_TWO_PI;
      return q;
   endfunction

   function automatic void spin(inout longint x, inout longint y, input longint z);
      longint cx, cy, nx;
      cx = x;
      cy = y;
      if (z > ANG_HALF_PI) begin
         z -= ANG_PI; cx = -cx; cy = -cy;
      end else if (z < -ANG_HALF_PI) begin
         z += ANG_PI; cx = -cx; cy = -cy;
      end
      for (int i = 0; i < 24; i++) begin
         if (z >= 0) begin
            nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= atan_step(i);
         end else begin
            nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += atan_step(i);
         end
         cx = nx;
      end
      x = scale_by_gain(cx);
      y = scale_by_gain(cy);
   endfunction

   function automatic void to_polar(input longint x, input longint y,
                                    output longint mag, output longint ang);
      longint z, nx;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0; ang = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? ANG_PI : -ANG_PI;
         x = -x; y = -y;
      end
      for (int i = 0; i < 24; i++) begin
         if (y < 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
         end
         x = nx;
      end
      if (z > ANG_PI) z -= ANG_TWO_PI;
      if (z <= -ANG_PI) z += ANG_TWO_PI;
      mag = scale_by_gain(x);
      ang = z;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] coord_word(longint v);
      return clamp32((v + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS);
   endfunction

   function automatic logic signed [31:0] angle_word(longint q);
      return clamp32((q + (longint'(1) << 13)) >>> 14);
   endfunction

   function automatic coord_result_type convert(coord_item_type it);
      coord_result_type res;
      longint a, b, c, x, y, z, m, t, p;
      a = it.first;
      b = it.second;
      c = it.third;
      res = '{32'sd0, 32'sd0, 32'sd0};
      case (it.op)
         OP_POLAR_TO_RECT, OP_CYL_TO_RECT: begin
            x = a <<< GUARD_BITS; y = 0;
            spin(x, y, wrap_angle(b));
            res.first = coord_word(x);
            res.second = coord_word(y);
            if (it.op == OP_CYL_TO_RECT) res.third = it.third;
         end
         OP_RECT_TO_POLAR, OP_RECT_TO_CYL: begin
            to_polar(a <<< GUARD_BITS, b <<< GUARD_BITS, m, t);
            res.first = coord_word(m);
            res.second = angle_word(t);
            if (it.op == OP_RECT_TO_CYL) res.third = it.third;
         end
         OP_SPH_TO_RECT: begin
            x = a <<< GUARD_BITS; z = 0;
            spin(x, z, wrap_angle(c));
            y = 0;
            spin(x, y, wrap_angle(b));
            res.first = coord_word(x);
            res.second = coord_word(y);
            res.third = coord_word(z);
         end
         OP_RECT_TO_SPH: begin
            to_polar(a <<< GUARD_BITS, b <<< GUARD_BITS, m, t);
            to_polar(m, c <<< GUARD_BITS, x, p);
            res.first = coord_word(x);
            res.second = angle_word(t);
            res.third = angle_word(p);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 40 << 16) - (20 << 16);
         2: return $urandom_range(0, 2000 << 16) - (1000 << 16);
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: return $urandom_range(0, 14 << 16) - (7 << 16);
      endcase
   endfunction

   function automatic coord_item_type random_item();
      coord_item_type it;
      it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      it.first = pick_value();
      it.second = pick_value();
      it.third = pick_value();
      return it;
   endfunction

   task automatic add_item(logic [2:0] op, logic signed [31:0] f, logic signed [31:0] s,
                           logic signed [31:0] t);
      pending_items.push_back('{op, f, s, t});
      total_items++;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_push || expected_coords.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      coord_item_type it;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            it = '{req_operation, req_in_first, req_in_second, req_in_third};
            expected_coords.push_back(convert(it));
            op_seen[req_operation]++;
            sent_count++;
            if (sent_count >= total_items - QUIET_TAIL && total_items > 1000) quiet = 1'b1;
         end
         if (!(req_push && req_full)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 15) - 1;
               req_push <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_push <= 1'b1;
               req_operation <= it.op;
               req_in_first <= it.first;
               req_in_second <= it.second;
               req_in_third <= it.third;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold while the sender keeps going
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && sent_count >= 300) begin
            hold_left <= 600;
            hold_done <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      coord_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            recv_count++;
            if (expected_coords.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: %h %h %h",
                           rsp_out_first, rsp_out_second, rsp_out_third);
            end else begin
               want = expected_coords.pop_front();
               if (rsp_out_first !== want.first || rsp_out_second !== want.second ||
                   rsp_out_third !== want.third) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at result %0d: expected %h %h %h, got %h %h %h",
                              recv_count, want.first, want.second, want.third,
                              rsp_out_first, rsp_out_second, rsp_out_third);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(1, 15) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_item(OP_POLAR_TO_RECT, 32'sh00010000, 32'sh00000000, 32'sd0);
      add_item(OP_POLAR_TO_RECT, 32'sh7FFFFFFF, 32'sh0001921F, 32'sd5);
      add_item(OP_POLAR_TO_RECT, -32'sh00030000, 32'sh80000000, 32'sd0);
      add_item(OP_RECT_TO_POLAR, 32'sd0, 32'sd0, 32'sh12345678);
      add_item(OP_RECT_TO_POLAR, 32'sh80000000, 32'sh80000000, 32'sd0);
      add_item(OP_RECT_TO_POLAR, -32'sh00020000, 32'sd0, 32'sd0);
      add_item(OP_RECT_TO_POLAR, -32'sh00020000, -32'sd1, 32'sd0);
      add_item(OP_CYL_TO_RECT, 32'sh00050000, 32'sh7FFFFFFF, 32'sh80000000);
      add_item(OP_CYL_TO_RECT, 32'sh80000000, 32'sh00032440, 32'sh7FFFFFFF);
      add_item(OP_RECT_TO_CYL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sd1);
      add_item(OP_RECT_TO_CYL, -32'sh00010000, 32'sh00010000, 32'sh00010000);
      add_item(OP_SPH_TO_RECT, 32'sh00040000, 32'sh0000C910, 32'sh0000C910);
      add_item(OP_SPH_TO_RECT, -32'sh7FFFFFFF, -32'sh0001921F, 32'sh80000000);
      add_item(OP_RECT_TO_SPH, 32'sd0, 32'sd0, 32'sd0);
      add_item(OP_RECT_TO_SPH, 32'sd0, 32'sd0, -32'sh00010000);
      add_item(OP_RECT_TO_SPH, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      add_item(OP_RECT_TO_SPH, -32'sh00010000, -32'sh00020000, 32'sh00030000);
      add_item(OP_SPARE_A, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_item(OP_SPARE_B, 32'sh80000000, -32'sd1, 32'sd1);
      wait_drained();

      for (int i = 0; i < 600; i++) pending_items.push_back(random_item());
      total_items += 600;
      wait_drained();

      for (int i = 600; i < RANDOM_ITEMS; i++) pending_items.push_back(random_item());
      total_items += RANDOM_ITEMS - 600;
      wait_drained();
      repeat (200) @(posedge clock);

      $display("%0d conversions sent, %0d results checked, %0d receiver hold cycles",
               sent_count, recv_count, 600);
      $display("per operation code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3],
               op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
      if (mismatch_count == 0 && expected_coords.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout waiting for results");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
